/* src/lsal_pkg.sv */
// lsal_pkg: widths, coefficients, register indexes and the microcode program
// of the light sensor lux unit. Used by light_sensor_autorange_lux_unit.
`default_nettype none
package lsal_pkg;

  localparam int RAW_W      = 16;
  localparam int LUX_W      = 40;
  localparam int GAIN_W     = 2;
  localparam int INT_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int STEP_W     = 5;
  localparam int NINE_W     = 20;   // raw count times nine
  localparam int Q_W        = 10;   // quotient and remainder of the first division
  localparam int MAG_W      = 64;
  localparam int MUL_A_W    = 32;
  localparam int RECIP_W    = 34;
  localparam int RECIP_SH   = 43;
  localparam int FINAL_SH   = 32;

  localparam logic [GAIN_W-1:0] GAIN_MAX = 2'd3;
  localparam logic [INT_W-1:0]  INT_MAX  = 3'd5;
  localparam logic [NINE_W-1:0] DIV_K    = 20'd625;

  // ceil(2^43 / 625), exact for every dividend below 2^33
  localparam logic [RECIP_W-1:0] RECIP = 34'd14073748836;

  localparam logic [LUX_W-1:0] LUX_MAX = {LUX_W{1'b1}};

  localparam logic [MAG_W-1:0]        C4 = 64'd726987541625;
  localparam logic signed [MAG_W-1:0] C3 = 64'sd173259199038;
  localparam logic signed [MAG_W-1:0] C2 = 64'sd22936832902;
  localparam logic signed [MAG_W-1:0] C1 = 64'sd4304845721;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AUTO_ENABLE       = 3'd0,
    REG_START_GAIN        = 3'd1,
    REG_START_INTEGRATION = 3'd2,
    REG_LOW_THRESHOLD     = 3'd3,
    REG_HIGH_THRESHOLD    = 3'd4
  } reg_index_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_DIV1,
    OP_XFORM,
    OP_SETUP,
    OP_HORNER,
    OP_POLY_END,
    OP_OUTPUT
  } op_t;

  typedef enum logic { B_RECIP, B_X } bsel_t;

  typedef enum logic [1:0] { SH_RECIP, SH_POLY, SH_FINAL } shsel_t;

  typedef enum logic [1:0] { COEF_C3N, COEF_C2, COEF_C1 } coef_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_WAIT_IN,
    COND_WAIT_OUT,
    COND_NOCORR,
    COND_GOTO
  } cond_t;

  typedef struct packed {
    op_t               op;
    bsel_t             bsel;
    shsel_t            shsel;
    coef_t             coef;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  localparam logic [STEP_W-1:0] STEP_IDLE   = 5'd0;
  localparam logic [STEP_W-1:0] STEP_OUTPUT = 5'd20;

  function automatic ctrl_t uword(op_t op, bsel_t b, shsel_t sh, coef_t c, cond_t cd,
                                  logic [STEP_W-1:0] tgt);
    ctrl_t w;
    w.op     = op;
    w.bsel   = b;
    w.shsel  = sh;
    w.coef   = c;
    w.cond   = cd;
    w.target = tgt;
    return w;
  endfunction

  // program: first division, fraction division, then the horner chain
  function automatic ctrl_t ucode(logic [STEP_W-1:0] step);
    ctrl_t w;
    unique case (step)
      5'd0:    w = uword(OP_LOAD,     B_RECIP, SH_RECIP, COEF_C3N, COND_WAIT_IN,  STEP_IDLE);
      5'd1:    w = uword(OP_MUL_LO,   B_RECIP, SH_RECIP, COEF_C3N, COND_NEXT,     STEP_IDLE);
      5'd2:    w = uword(OP_MUL_HI,   B_RECIP, SH_RECIP, COEF_C3N, COND_NEXT,     STEP_IDLE);
      5'd3:    w = uword(OP_DIV1,     B_RECIP, SH_RECIP, COEF_C3N, COND_NEXT,     STEP_IDLE);
      5'd4:    w = uword(OP_MUL_LO,   B_RECIP, SH_RECIP, COEF_C3N, COND_NEXT,     STEP_IDLE);
      5'd5:    w = uword(OP_MUL_HI,   B_RECIP, SH_RECIP, COEF_C3N, COND_NEXT,     STEP_IDLE);
      5'd6:    w = uword(OP_XFORM,    B_RECIP, SH_RECIP, COEF_C3N, COND_NEXT,     STEP_IDLE);
      5'd7:    w = uword(OP_SETUP,    B_X,     SH_POLY,  COEF_C3N, COND_NOCORR,   STEP_OUTPUT);
      5'd8:    w = uword(OP_MUL_LO,   B_X,     SH_POLY,  COEF_C3N, COND_NEXT,     STEP_IDLE);
      5'd9:    w = uword(OP_MUL_HI,   B_X,     SH_POLY,  COEF_C3N, COND_NEXT,     STEP_IDLE);
      5'd10:   w = uword(OP_HORNER,   B_X,     SH_POLY,  COEF_C3N, COND_NEXT,     STEP_IDLE);
      5'd11:   w = uword(OP_MUL_LO,   B_X,     SH_POLY,  COEF_C2,  COND_NEXT,     STEP_IDLE);
      5'd12:   w = uword(OP_MUL_HI,   B_X,     SH_POLY,  COEF_C2,  COND_NEXT,     STEP_IDLE);
      5'd13:   w = uword(OP_HORNER,   B_X,     SH_POLY,  COEF_C2,  COND_NEXT,     STEP_IDLE);
      5'd14:   w = uword(OP_MUL_LO,   B_X,     SH_POLY,  COEF_C1,  COND_NEXT,     STEP_IDLE);
      5'd15:   w = uword(OP_MUL_HI,   B_X,     SH_POLY,  COEF_C1,  COND_NEXT,     STEP_IDLE);
      5'd16:   w = uword(OP_HORNER,   B_X,     SH_POLY,  COEF_C1,  COND_NEXT,     STEP_IDLE);
      5'd17:   w = uword(OP_MUL_LO,   B_X,     SH_FINAL, COEF_C1,  COND_NEXT,     STEP_IDLE);
      5'd18:   w = uword(OP_MUL_HI,   B_X,     SH_FINAL, COEF_C1,  COND_NEXT,     STEP_IDLE);
      5'd19:   w = uword(OP_POLY_END, B_X,     SH_FINAL, COEF_C1,  COND_NEXT,     STEP_IDLE);
      5'd20:   w = uword(OP_OUTPUT,   B_X,     SH_FINAL, COEF_C1,  COND_WAIT_OUT, STEP_IDLE);
      default: w = uword(OP_NONE,     B_RECIP, SH_RECIP, COEF_C3N, COND_GOTO,     STEP_IDLE);
    endcase
    return w;
  endfunction

  // gain multipliers 1, 2, 8, 16 as shift amounts
  function automatic logic [2:0] gain_shift(logic [GAIN_W-1:0] g);
    logic [2:0] s;
    unique case (g)
      2'd0:    s = 3'd0;
      2'd1:    s = 3'd1;
      2'd2:    s = 3'd3;
      default: s = 3'd4;
    endcase
    return s;
  endfunction

  function automatic logic [LUX_W-1:0] lux_sat(logic [MAG_W-1:0] v);
    return (v > MAG_W'(LUX_MAX)) ? LUX_MAX : v[LUX_W-1:0];
  endfunction

  function automatic logic [NINE_W-1:0] times9(logic [RAW_W-1:0] v);
    return NINE_W'({v, 3'b000}) + NINE_W'(v);
  endfunction

endpackage
`default_nettype wire

/* src/light_sensor_autorange_lux_unit.sv */
// light_sensor_autorange_lux_unit: raw light count to lux with auto ranging,
// run by a microcoded sequencer over one shared multiplier. Needs lsal_pkg.
//
//  channel  direction  handshake            payload
//  in       sink       in_valid / in_stall  raw_count
//  out      source     out_valid/out_stall  lux_value, gain_used, integration_used,
//                                           corrected, next_gain, next_integration,
//                                           range_changed
//  cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// an item skips the polynomial steps when no correction applies and runs them when
// one does; each product is two passes of the 32x34 multiplier, and the step
// counter walks the microcode one word per cycle except while waiting on a channel.
// reset is synchronous and needs no clearing pass; cfg_ready is always high.
// the result sits in an output register, so the next item is taken while it waits;
// the last step holds only while an earlier result is still stalled.
`default_nettype none
module light_sensor_autorange_lux_unit
  import lsal_pkg::*;
#(
  parameter int LUX_FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [RAW_W-1:0]      raw_count,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [LUX_W-1:0]      lux_value,
  output logic [GAIN_W-1:0]     gain_used,
  output logic [INT_W-1:0]      integration_used,
  output logic                  corrected,
  output logic [GAIN_W-1:0]     next_gain,
  output logic [INT_W-1:0]      next_integration,
  output logic                  range_changed,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int XW      = 17 + LUX_FRAC_BITS;     // width of the base lux value
  localparam int SMAX    = 7 + LUX_FRAC_BITS;
  localparam int SW      = $clog2(SMAX + 1);
  localparam int SH_P    = LUX_FRAC_BITS + 16;
  localparam int BW      = (XW > RECIP_W) ? XW : RECIP_W;
  localparam int PW      = MUL_A_W + BW;
  localparam int AW      = MAG_W + BW;
  localparam logic [XW-1:0] CORR_LIMIT = XW'(1000) << LUX_FRAC_BITS;

  // configuration and range state
  logic                auto_enable;
  logic [RAW_W-1:0]    low_threshold;
  logic [RAW_W-1:0]    high_threshold;
  logic [GAIN_W-1:0]   cur_gain;
  logic [INT_W-1:0]    cur_integration;

  // sequencer
  logic [STEP_W-1:0]   step;
  logic [STEP_W-1:0]   step_next;
  ctrl_t               ctrl;

  // datapath registers
  logic [RAW_W-1:0]    cnt;
  logic [GAIN_W-1:0]   g;
  logic [INT_W-1:0]    it;
  logic [MAG_W-1:0]    amag;
  logic                neg;
  logic [AW-1:0]       acc;
  logic [Q_W-1:0]      qreg;
  logic [XW-1:0]       xr;
  logic                corr;
  logic [LUX_W-1:0]    lux_r;

  logic                accept;
  logic                out_free;
  logic                adv_out;
  logic [MUL_A_W-1:0]  mul_a;
  logic [BW-1:0]       mul_b;
  logic [PW-1:0]       prod;
  logic [AW-1:0]       acc_sh;
  logic [3:0]          kshift;
  logic [SW-1:0]       s_amt;
  logic [NINE_W-1:0]   rem1;
  logic [XW-1:0]       t_val;
  logic [XW-1:0]       x_next;
  logic signed [MAG_W-1:0] coef_v;
  logic signed [MAG_W-1:0] sm;
  logic signed [MAG_W-1:0] h_val;
  logic [GAIN_W-1:0]   ng;
  logic [INT_W-1:0]    nit;

  assign ctrl      = ucode(step);
  assign in_stall  = (step != STEP_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign adv_out   = (ctrl.op == OP_OUTPUT) && out_free;
  assign cfg_ready = 1'b1;

  // step counter with conditional jumps
  always_comb begin
    unique case (ctrl.cond)
      COND_WAIT_IN:  step_next = accept ? step + 1'b1 : step;
      COND_WAIT_OUT: step_next = out_free ? ctrl.target : step;
      COND_NOCORR:   step_next = corr ? step + 1'b1 : ctrl.target;
      COND_GOTO:     step_next = ctrl.target;
      default:       step_next = step + 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // shared multiplier: one 32-bit slice of the magnitude per pass
  assign mul_a = (ctrl.op == OP_MUL_HI) ? amag[MAG_W-1:MUL_A_W] : amag[MUL_A_W-1:0];
  assign mul_b = (ctrl.bsel == B_X) ? BW'(xr) : BW'(RECIP);
  assign prod  = PW'(mul_a) * PW'(mul_b);

  always_comb begin
    unique case (ctrl.shsel)
      SH_POLY:  acc_sh = acc >> SH_P;
      SH_FINAL: acc_sh = acc >> FINAL_SH;
      default:  acc_sh = acc >> RECIP_SH;
    endcase
  end

  // total right shift of gain and integration, and the left shift that remains
  assign kshift = 4'(gain_shift(g)) + 4'(it);
  assign s_amt  = SW'(SMAX) - SW'(kshift);

  // remainder of count*9 / 625 carried into the fraction division
  assign rem1   = times9(cnt) - (NINE_W'(acc_sh[Q_W-1:0]) * DIV_K);
  assign t_val  = XW'(rem1[Q_W-1:0]) << s_amt;
  assign x_next = (XW'(qreg) << s_amt) + acc_sh[XW-1:0];

  always_comb begin
    unique case (ctrl.coef)
      COEF_C2: coef_v = C2;
      COEF_C1: coef_v = C1;
      default: coef_v = -C3;
    endcase
  end

  // products are truncated toward zero, so the sign rides beside the magnitude
  assign sm    = neg ? -$signed(acc_sh[MAG_W-1:0]) : $signed(acc_sh[MAG_W-1:0]);
  assign h_val = sm + coef_v;

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_LOAD: begin
        if (accept) begin
          cnt  <= raw_count;
          g    <= cur_gain;
          it   <= cur_integration;
          amag <= MAG_W'(times9(raw_count));
          neg  <= 1'b0;
        end
      end
      OP_MUL_LO:   acc <= AW'(prod);
      OP_MUL_HI:   acc <= acc + (AW'(prod) << MUL_A_W);
      OP_DIV1: begin
        qreg <= acc_sh[Q_W-1:0];
        amag <= MAG_W'(t_val);
      end
      OP_XFORM: begin
        xr   <= x_next;
        corr <= (g <= 2'd1) && (x_next > CORR_LIMIT);
      end
      OP_SETUP: begin
        amag  <= C4;
        neg   <= 1'b0;
        lux_r <= lux_sat(MAG_W'(xr));
      end
      OP_HORNER: begin
        neg  <= h_val[MAG_W-1];
        amag <= h_val[MAG_W-1] ? MAG_W'(-h_val) : MAG_W'(h_val);
      end
      OP_POLY_END: lux_r <= neg ? '0 : lux_sat(acc_sh[MAG_W-1:0]);
      default: ;
    endcase
  end

  // auto ranging: raise first, then lower acts on the raised settings
  always_comb begin
    ng  = g;
    nit = it;
    if (auto_enable) begin
      if (cnt < low_threshold) begin
        if (ng == GAIN_MAX) begin
          if (nit < INT_MAX) nit = nit + 1'b1;
        end else begin
          ng = ng + 1'b1;
        end
      end
      if (cnt > high_threshold) begin
        if (nit == '0) begin
          if (ng != '0) ng = ng - 1'b1;
        end else begin
          nit = nit - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_enable     <= 1'b0;
      low_threshold   <= 16'd101;
      high_threshold  <= 16'd10000;
      cur_gain        <= 2'd0;
      cur_integration <= 3'd2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_AUTO_ENABLE:       auto_enable <= cfg_data[0];
        REG_START_GAIN:        cur_gain <= cfg_data[GAIN_W-1:0];
        REG_START_INTEGRATION: begin
          cur_integration <= (cfg_data[INT_W-1:0] > INT_MAX) ? INT_MAX
                                                              : cfg_data[INT_W-1:0];
        end
        REG_LOW_THRESHOLD:     low_threshold <= cfg_data[RAW_W-1:0];
        REG_HIGH_THRESHOLD:    high_threshold <= cfg_data[RAW_W-1:0];
        default: ;
      endcase
    end else if (adv_out) begin
      cur_gain        <= ng;
      cur_integration <= nit;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      lux_value        <= lux_r;
      gain_used        <= g;
      integration_used <= it;
      corrected        <= corr;
      next_gain        <= ng;
      next_integration <= nit;
      range_changed    <= (ng != g) || (nit != it);
    end
  end

`ifndef ASSERT_OFF
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("input taken again before the sequencer finished");

  a_corr_low_gain: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!corrected || gain_used <= 2'd1))
    else $error("correction flagged at a high gain");

  a_uncorr_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !corrected) |-> ((lux_value >> XW) == '0))
    else $error("uncorrected lux wider than the base value");

  a_next_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (next_integration <= INT_MAX && integration_used <= INT_MAX))
    else $error("integration index out of range");

  a_changed_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (range_changed ==
                   ((next_gain != gain_used) || (next_integration != integration_used))))
    else $error("range change flag disagrees with the settings");
`endif

endmodule
`default_nettype wire
